### hdl/lics_pkg.sv
`timescale 1ns / 1ps
// shared types, widths, constants, log and reciprocal tables for the laplace sampler
// no dependencies
package lics_pkg;

	localparam int UNIFORM_BITS     = 16;
	localparam int RESULT_FRAC_BITS = 8;

	localparam int IN_W  = 16;
	localparam int OUT_W = 24;
	localparam int CFG_W = 16;

	localparam int NSTAGES = 8;

	localparam int N_W = UNIFORM_BITS - 1;
	localparam int K_W = $clog2(N_W);
	localparam int E_W = $clog2(UNIFORM_BITS);

	localparam int LN2_Q16 = 45426;
	localparam int NL_W    = $clog2(N_W * LN2_Q16 + 1);
	localparam int PROD_W  = CFG_W + NL_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int RND_SH  = 24 - RESULT_FRAC_BITS;

	localparam int THIRD_MUL   = 171;
	localparam int THIRD_SHIFT = 9;

	localparam logic [UNIFORM_BITS-1:0] U_HALF = {1'b1, {(UNIFORM_BITS-1){1'b0}}};

	localparam logic signed [SUM_W-1:0] ROUND_ADD   = SUM_W'(1) << (RND_SH - 1);
	localparam logic signed [SUM_W-1:0] SUM_OUT_MAX = SUM_W'(2**(OUT_W-1) - 1);
	localparam logic signed [SUM_W-1:0] SUM_OUT_MIN = -(SUM_W'(2**(OUT_W-1)));
	localparam logic signed [OUT_W-1:0] OUT_MAX_V   = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN_V   = {1'b1, {(OUT_W-1){1'b0}}};

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_LOCATION = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SCALE    = 1'b1;

	localparam logic [CFG_W-1:0] LOCATION_RST = 16'h0000;
	localparam logic [CFG_W-1:0] SCALE_RST    = 16'h0100;

	typedef struct packed {
		logic zero;
		logic half;
		logic pos;
	} lics_ctl_t;

	// ln(1 + i/8) in q16
	function automatic logic [15:0] lics_lntab(input logic [2:0] i);
		logic [15:0] v;
		case (i)
			3'd0: v = 16'd0;
			3'd1: v = 16'd7719;
			3'd2: v = 16'd14624;
			3'd3: v = 16'd20870;
			3'd4: v = 16'd26573;
			3'd5: v = 16'd31818;
			3'd6: v = 16'd36675;
			3'd7: v = 16'd41196;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// 1 / (1 + i/8) in q16
	function automatic logic [16:0] lics_recip(input logic [2:0] i);
		logic [16:0] v;
		case (i)
			3'd0: v = 17'd65536;
			3'd1: v = 17'd58254;
			3'd2: v = 17'd52429;
			3'd3: v = 17'd47663;
			3'd4: v = 17'd43691;
			3'd5: v = 17'd40330;
			3'd6: v = 17'd37449;
			3'd7: v = 17'd34953;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

### hdl/lics_front.sv
`timescale 1ns / 1ps
// stages 1-2: input classification, folding about one half, normalization
// depends on lics_pkg
module lics_front (
	input  logic                         clk,
	input  logic [1:0]                   en,
	input  logic [lics_pkg::IN_W-1:0]    uniform_sample,
	output lics_pkg::lics_ctl_t          ctl_s2,
	output logic [lics_pkg::E_W-1:0]     e_s2,
	output logic [2:0]                   i_s2,
	output logic [12:0]                  d_s2
);
	import lics_pkg::*;

	logic [UNIFORM_BITS-1:0] u;
	logic [UNIFORM_BITS:0]   comp;
	logic [N_W-1:0]          n_c;
	lics_ctl_t               ctl_c;

	logic [N_W-1:0] n_s1;
	lics_ctl_t      ctl_s1;

	logic [K_W-1:0]    k_c;
	logic [N_W+15:0]   norm_c;
	logic [15:0]       f_c;
	logic [E_W-1:0]    e_c;

	always_comb begin
		u          = UNIFORM_BITS'(uniform_sample);
		comp       = {1'b1, {UNIFORM_BITS{1'b0}}} - {1'b0, u};
		ctl_c.zero = (u == '0);
		ctl_c.half = (u == U_HALF);
		ctl_c.pos  = (u > U_HALF);
		n_c        = ctl_c.pos ? comp[N_W-1:0] : u[N_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			n_s1   <= n_c;
			ctl_s1 <= ctl_c;
		end
	end

	// leading one position
	always_comb begin
		k_c = '0;
		for (int b = 0; b < N_W; b++) begin
			if (n_s1[b]) k_c = K_W'(b);
		end
		norm_c = {n_s1, 16'h0000} >> k_c;
		f_c    = norm_c[15:0];
		e_c    = E_W'(N_W) - E_W'(k_c);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ctl_s2 <= ctl_s1;
			e_s2   <= e_c;
			i_s2   <= f_c[15:13];
			d_s2   <= f_c[12:0];
		end
	end

endmodule

### hdl/lics_log.sv
`timescale 1ns / 1ps
// stages 3-6: table plus cubic natural log, negated and offset by the exponent
// depends on lics_pkg
module lics_log (
	input  logic                          clk,
	input  logic [3:0]                    en,
	input  lics_pkg::lics_ctl_t           ctl_s2,
	input  logic [lics_pkg::E_W-1:0]      e_s2,
	input  logic [2:0]                    i_s2,
	input  logic [12:0]                   d_s2,
	output lics_pkg::lics_ctl_t           ctl_s6,
	output logic [lics_pkg::NL_W-1:0]     nl_s6
);
	import lics_pkg::*;

	logic [29:0] m1_c;
	logic [12:0] w_s3;
	logic [2:0]  i_s3;
	logic [E_W-1:0] e_s3;
	lics_ctl_t   ctl_s3;

	logic [25:0] m2_c;
	logic [9:0]  w2_s4;
	logic [12:0] w_s4;
	logic [2:0]  i_s4;
	logic [E_W-1:0] e_s4;
	lics_ctl_t   ctl_s4;

	logic [22:0]     m3_c;
	logic [16:0]     part_c;
	logic [NL_W-1:0] eln2_c;
	logic [6:0]      w3_s5;
	logic [16:0]     part_s5;
	logic [NL_W-1:0] eln2_s5;
	lics_ctl_t       ctl_s5;

	logic [14:0]     third_m_c;
	logic [16:0]     lnm_c;
	logic [NL_W-1:0] nl_c;

	assign m1_c = 30'(d_s2) * 30'(lics_recip(i_s2));

	always_ff @(posedge clk) begin
		if (en[0]) begin
			w_s3   <= m1_c[28:16];
			i_s3   <= i_s2;
			e_s3   <= e_s2;
			ctl_s3 <= ctl_s2;
		end
	end

	assign m2_c = 26'(w_s3) * 26'(w_s3);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			w2_s4  <= m2_c[25:16];
			w_s4   <= w_s3;
			i_s4   <= i_s3;
			e_s4   <= e_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	always_comb begin
		m3_c   = 23'(w2_s4) * 23'(w_s4);
		part_c = 17'(lics_lntab(i_s4)) + 17'(w_s4) - 17'(w2_s4[9:1]);
		eln2_c = NL_W'(e_s4) * NL_W'(LN2_Q16);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			w3_s5   <= m3_c[22:16];
			part_s5 <= part_c;
			eln2_s5 <= eln2_c;
			ctl_s5  <= ctl_s4;
		end
	end

	// cube term divided by three
	always_comb begin
		third_m_c = 15'(w3_s5) * 15'(THIRD_MUL);
		lnm_c     = part_s5 + 17'(third_m_c >> THIRD_SHIFT);
		nl_c      = eln2_s5 - NL_W'(lnm_c);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			nl_s6  <= nl_c;
			ctl_s6 <= ctl_s5;
		end
	end

endmodule

### hdl/lics_out.sv
`timescale 1ns / 1ps
// stages 7-8: scale multiply, location add, rounding and saturation
// depends on lics_pkg
module lics_out (
	input  logic                              clk,
	input  logic [1:0]                        en,
	input  lics_pkg::lics_ctl_t               ctl_s6,
	input  logic [lics_pkg::NL_W-1:0]         nl_s6,
	input  logic signed [lics_pkg::CFG_W-1:0] location,
	input  logic [lics_pkg::CFG_W-1:0]        scale,
	output logic signed [lics_pkg::OUT_W-1:0] laplace_sample,
	output logic                              saturated
);
	import lics_pkg::*;

	logic [PROD_W-1:0] prod_s7;
	lics_ctl_t         ctl_s7;

	logic signed [SUM_W-1:0] loc_ext;
	logic signed [SUM_W-1:0] term;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] rounded;
	logic signed [OUT_W-1:0] y_c;
	logic                    sat_c;

	logic signed [OUT_W-1:0] sample_s8;
	logic                    sat_s8;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s7 <= PROD_W'(scale) * PROD_W'(nl_s6);
			ctl_s7  <= ctl_s6;
		end
	end

	always_comb begin
		loc_ext = {{(SUM_W-CFG_W-16){location[CFG_W-1]}}, location, 16'h0000};
		if (ctl_s7.half) begin
			term = '0;
		end else if (ctl_s7.pos) begin
			term = $signed({2'b00, prod_s7});
		end else begin
			term = -$signed({2'b00, prod_s7});
		end
		sum     = loc_ext + term;
		rounded = (sum + ROUND_ADD) >>> RND_SH;
		if (ctl_s7.zero) begin
			y_c   = OUT_MIN_V;
			sat_c = 1'b1;
		end else if (rounded > SUM_OUT_MAX) begin
			y_c   = OUT_MAX_V;
			sat_c = 1'b1;
		end else if (rounded < SUM_OUT_MIN) begin
			y_c   = OUT_MIN_V;
			sat_c = 1'b1;
		end else begin
			y_c   = rounded[OUT_W-1:0];
			sat_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sample_s8 <= y_c;
			sat_s8    <= sat_c;
		end
	end

	assign laplace_sample = sample_s8;
	assign saturated      = sat_s8;

endmodule

### hdl/laplace_inverse_cdf_sampler_core.sv
`timescale 1ns / 1ps
// top level of the laplace inverse cdf sampler: config registers, valid chain
// depends on lics_pkg, lics_front, lics_log, lics_out
//
// usage:
//   input channel sample_valid/sample_ready carries uniform_sample (q0.16);
//   output channel result_valid/result_ready carries laplace_sample (q15.8)
//   and saturated. a transaction happens when valid and ready are both high.
//   eight register stages; one transaction per cycle is sustained in both
//   directions while result_ready stays high.
//   each stage holds its own valid bit and advances when the next one is
//   free, so a stalled receiver holds the last result while empty stages
//   upstream keep filling; sample_ready falls only once all stages are full.
//   nothing is lost or repeated during a stall.
//   write_enable/register_index/write_data write location (0) and scale (1);
//   write only while the pipeline is empty.
//   reset empties the pipeline and sets location to 0 and scale to 1.0.
module laplace_inverse_cdf_sampler_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic [lics_pkg::IN_W-1:0]             uniform_sample,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [lics_pkg::OUT_W-1:0]     laplace_sample,
	output logic                                  saturated,
	input  logic                                  write_enable,
	input  logic [lics_pkg::REG_IDX_W-1:0]        register_index,
	input  logic [lics_pkg::CFG_W-1:0]            write_data
);
	import lics_pkg::*;

	logic [NSTAGES-1:0] stage_valid_q;
	logic [NSTAGES-1:0] stage_en;
	logic [CFG_W-1:0]   location_q;
	logic [CFG_W-1:0]   scale_q;

	lics_ctl_t       ctl_s2;
	logic [E_W-1:0]  e_s2;
	logic [2:0]      i_s2;
	logic [12:0]     d_s2;
	lics_ctl_t       ctl_s6;
	logic [NL_W-1:0] nl_s6;

	always_comb begin
		stage_en[NSTAGES-1] = !stage_valid_q[NSTAGES-1] || result_ready;
		for (int j = NSTAGES - 2; j >= 0; j--) begin
			stage_en[j] = !stage_valid_q[j] || stage_en[j+1];
		end
	end

	assign sample_ready = stage_en[0];
	assign result_valid = stage_valid_q[NSTAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (stage_en[0]) stage_valid_q[0] <= sample_valid;
			for (int j = 1; j < NSTAGES; j++) begin
				if (stage_en[j]) stage_valid_q[j] <= stage_valid_q[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			location_q <= LOCATION_RST;
			scale_q    <= SCALE_RST;
		end else if (write_enable) begin
			if (register_index == REG_LOCATION) location_q <= write_data;
			if (register_index == REG_SCALE)    scale_q    <= write_data;
		end
	end

	lics_front u_front (
		.clk            (clk),
		.en             (stage_en[1:0]),
		.uniform_sample (uniform_sample),
		.ctl_s2         (ctl_s2),
		.e_s2           (e_s2),
		.i_s2           (i_s2),
		.d_s2           (d_s2)
	);

	lics_log u_log (
		.clk    (clk),
		.en     (stage_en[5:2]),
		.ctl_s2 (ctl_s2),
		.e_s2   (e_s2),
		.i_s2   (i_s2),
		.d_s2   (d_s2),
		.ctl_s6 (ctl_s6),
		.nl_s6  (nl_s6)
	);

	lics_out u_out (
		.clk            (clk),
		.en             (stage_en[7:6]),
		.ctl_s6         (ctl_s6),
		.nl_s6          (nl_s6),
		.location       ($signed(location_q)),
		.scale          (scale_q),
		.laplace_sample (laplace_sample),
		.saturated      (saturated)
	);

endmodule
